// ===== src/mrwt_pkg.sv =====
// Package for the Miller-Rabin witness test core: widths, beat layouts,
// sequencer states and the modular double-and-add step. No dependencies.
`default_nettype none

package mrwt_pkg;

   localparam int VALUE_BITS = 15;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);

   // Request beat: base then candidate, padded to whole bytes.
   localparam int REQ_DATA_BITS = ((2 * VALUE_BITS + 7) / 8) * 8;
   // Response beat: probably_prime then bad_candidate, padded to a byte.
   localparam int RSP_DATA_BITS = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_REDUCE,
      ST_POW,
      ST_MUL_ACC,
      ST_MUL_BASE,
      ST_TEST,
      ST_SQUARE,
      ST_CHECK,
      ST_OUT
   } state_type;

   // One step of interleaved modular multiplication: returns (2p + (add ? y : 0)) mod n.
   // Requires p < n and y < n, so each half needs at most one subtraction.
   function automatic logic [VALUE_BITS-1:0] mod_step(
      input logic [VALUE_BITS-1:0] p,
      input logic                  add,
      input logic [VALUE_BITS-1:0] y,
      input logic [VALUE_BITS-1:0] n
   );
      logic [VALUE_BITS:0] t;
      logic [VALUE_BITS:0] u;
      t = {p, 1'b0};
      if (t >= {1'b0, n}) begin
         t = t - {1'b0, n};
      end
      u = t + (add ? {1'b0, y} : {(VALUE_BITS + 1){1'b0}});
      if (u >= {1'b0, n}) begin
         u = u - {1'b0, n};
      end
      return u[VALUE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/miller_rabin_witness_test_core.sv =====
// Miller-Rabin witness test core: one witness round per request beat, using a
// single bit-serial modular multiplier under a small sequencer. Uses mrwt_pkg.
//
// The steps are the candidate-1 split, which drops one trailing zero at a
// time, the base reduction, one or two multiplications per exponent bit and
// each extra squaring. The core takes one item at a time; the next request
// beat is taken once the result has moved to the output register.
// Candidates below 3 go straight to the output state.
// Reset is synchronous, active high, and clears the sequencer and valid flags.
`default_nettype none

module miller_rabin_witness_test_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [14:0] base, [29:15] candidate, upper bits zero
   input  wire logic [mrwt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] probably_prime, [1] bad_candidate, upper bits zero
   output logic [mrwt_pkg::RSP_DATA_BITS-1:0]     rsp_tdata
);

   localparam int VB = mrwt_pkg::VALUE_BITS;
   localparam int CB = mrwt_pkg::CNT_BITS;

   mrwt_pkg::state_type state_ff, state_in;

   logic [VB-1:0] base_ff, base_in;   // reduced base, later its running squares
   logic [VB-1:0] n_ff, n_in;
   logic [VB-1:0] nm1_ff, nm1_in;
   logic [VB-1:0] d_ff, d_in;         // remaining exponent bits
   logic [CB-1:0] k_ff, k_in;         // squarings still allowed
   logic [VB-1:0] acc_ff, acc_in;     // x in the round

   // Shared multiplier: mx is scanned from its top bit, my is the multiplicand.
   logic [VB-1:0] mx_ff, mx_in;
   logic [VB-1:0] my_ff, my_in;
   logic [VB-1:0] mp_ff, mp_in;
   logic [CB-1:0] cnt_ff, cnt_in;

   logic          pass_ff, pass_in;
   logic          bad_ff, bad_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_prime_ff, rsp_prime_in;
   logic          rsp_bad_ff, rsp_bad_in;

   logic [VB-1:0] req_base;
   logic [VB-1:0] req_cand;
   logic          req_fire;
   logic [VB-1:0] mp_next;
   logic          mul_last;
   logic          out_free;

   assign req_base = req_tdata[VB-1:0];
   assign req_cand = req_tdata[2*VB-1:VB];
   assign req_fire = req_tvalid && req_tready;
   assign mp_next  = mrwt_pkg::mod_step(mp_ff, mx_ff[VB-1], my_ff, n_ff);
   assign mul_last = (cnt_ff == CB'(VB - 1));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == mrwt_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mrwt_pkg::RSP_DATA_BITS - 2){1'b0}}, rsp_bad_ff, rsp_prime_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrwt_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_cand < VB'(3)) ? mrwt_pkg::ST_OUT : mrwt_pkg::ST_SPLIT;
            end
         end
         mrwt_pkg::ST_SPLIT: begin
            if (d_ff[0]) begin
               state_in = mrwt_pkg::ST_REDUCE;
            end
         end
         mrwt_pkg::ST_REDUCE: begin
            if (mul_last) begin
               state_in = mrwt_pkg::ST_POW;
            end
         end
         mrwt_pkg::ST_POW: begin
            if (d_ff == '0) begin
               state_in = mrwt_pkg::ST_TEST;
            end else if (d_ff[0]) begin
               state_in = mrwt_pkg::ST_MUL_ACC;
            end else begin
               state_in = mrwt_pkg::ST_MUL_BASE;
            end
         end
         mrwt_pkg::ST_MUL_ACC: begin
            if (mul_last) begin
               state_in = mrwt_pkg::ST_MUL_BASE;
            end
         end
         mrwt_pkg::ST_MUL_BASE: begin
            if (mul_last) begin
               state_in = mrwt_pkg::ST_POW;
            end
         end
         mrwt_pkg::ST_TEST: begin
            if (acc_ff == VB'(1) || acc_ff == nm1_ff || k_ff == '0) begin
               state_in = mrwt_pkg::ST_OUT;
            end else begin
               state_in = mrwt_pkg::ST_SQUARE;
            end
         end
         mrwt_pkg::ST_SQUARE: begin
            if (mul_last) begin
               state_in = mrwt_pkg::ST_CHECK;
            end
         end
         mrwt_pkg::ST_CHECK: begin
            if (acc_ff == VB'(1) || acc_ff == nm1_ff || k_ff == '0) begin
               state_in = mrwt_pkg::ST_OUT;
            end else begin
               state_in = mrwt_pkg::ST_SQUARE;
            end
         end
         mrwt_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = mrwt_pkg::ST_IDLE;
            end
         end
         default: state_in = mrwt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      base_in      = base_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      mp_in        = mp_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_prime_in = rsp_prime_ff;
      rsp_bad_in   = rsp_bad_ff;

      // Every multiplier state advances the shared unit by one bit.
      if (state_ff == mrwt_pkg::ST_REDUCE || state_ff == mrwt_pkg::ST_MUL_ACC ||
          state_ff == mrwt_pkg::ST_MUL_BASE || state_ff == mrwt_pkg::ST_SQUARE) begin
         mp_in  = mp_next;
         mx_in  = {mx_ff[VB-2:0], 1'b0};
         cnt_in = cnt_ff + CB'(1);
      end

      unique case (state_ff)
         mrwt_pkg::ST_IDLE: begin
            if (req_fire) begin
               base_in = req_base;
               n_in    = req_cand;
               nm1_in  = req_cand - VB'(1);
               d_in    = req_cand - VB'(1);
               k_in    = '0;
               pass_in = 1'b0;
               bad_in  = (req_cand < VB'(3));
            end
         end
         mrwt_pkg::ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[VB-1:1]};
               k_in = k_ff + CB'(1);
            end else begin
               // Reduce the base by multiplying it by one.
               mx_in  = base_ff;
               my_in  = VB'(1);
               mp_in  = '0;
               cnt_in = '0;
            end
         end
         mrwt_pkg::ST_REDUCE: begin
            if (mul_last) begin
               base_in = mp_next;
               acc_in  = VB'(1);
            end
         end
         mrwt_pkg::ST_POW: begin
            mp_in  = '0;
            cnt_in = '0;
            if (d_ff[0]) begin
               mx_in = acc_ff;
               my_in = base_ff;
            end else begin
               mx_in = base_ff;
               my_in = base_ff;
            end
         end
         mrwt_pkg::ST_MUL_ACC: begin
            if (mul_last) begin
               acc_in = mp_next;
               mx_in  = base_ff;
               my_in  = base_ff;
               mp_in  = '0;
               cnt_in = '0;
            end
         end
         mrwt_pkg::ST_MUL_BASE: begin
            if (mul_last) begin
               base_in = mp_next;
               d_in    = {1'b0, d_ff[VB-1:1]};
            end
         end
         mrwt_pkg::ST_TEST, mrwt_pkg::ST_CHECK: begin
            // Leaving for the result: pass only on candidate-1, or on one
            // when it comes straight from the power.
            if (acc_ff == nm1_ff) begin
               pass_in = 1'b1;
            end else if (acc_ff == VB'(1)) begin
               pass_in = (state_ff == mrwt_pkg::ST_TEST);
            end else if (k_ff == '0) begin
               pass_in = 1'b0;
            end else begin
               mx_in  = acc_ff;
               my_in  = acc_ff;
               mp_in  = '0;
               cnt_in = '0;
            end
         end
         mrwt_pkg::ST_SQUARE: begin
            if (mul_last) begin
               acc_in = mp_next;
               k_in   = k_ff - CB'(1);
            end
         end
         mrwt_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = pass_ff && !bad_ff;
               rsp_bad_in   = bad_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrwt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      n_ff         <= n_in;
      nm1_ff       <= nm1_in;
      d_ff         <= d_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      mp_ff        <= mp_in;
      cnt_ff       <= cnt_in;
      pass_ff      <= pass_in;
      bad_ff       <= bad_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

endmodule

`default_nettype wire

// ===== src/mrwt_checker.sv =====
// Port-level checks for the Miller-Rabin witness test core, bound to the top
// level. Depends on mrwt_pkg and miller_rabin_witness_test_core.
`default_nettype none

module mrwt_assertions (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [mrwt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [mrwt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // A stalled response beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // An untested candidate is never reported as probably prime.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("bad candidate reported as probably prime");

   // The core works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

   // A request taken while no response is pending is not answered at once.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[mrwt_pkg::RSP_DATA_BITS-1:2] == '0)
      else $error("response padding bits not zero");

endmodule

bind miller_rabin_witness_test_core mrwt_assertions u_mrwt_assertions (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/mrwt_checker.sv =====
// Checker for the Miller-Rabin witness test core: watches both streams, predicts each
// verdict from the request beat and compares it with the response beat. Uses mrwt_pkg.
`timescale 1ns / 100ps

module mrwt_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // [14:0] base, [29:15] candidate, upper bits zero
   input  wire logic [mrwt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] probably_prime, [1] bad_candidate, upper bits zero
   input  wire logic [mrwt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                     error_count,
   output int                                     pending_count
);

   localparam int VB = mrwt_pkg::VALUE_BITS;

   typedef struct packed {
      logic bad_candidate;
      logic probably_prime;
   } verdict_type;

   verdict_type verdict_q[$];
   int          reports_shown;

   // Products of two residues need twice the value width, so nothing wraps.
   function automatic verdict_type predict_verdict(input logic [VB-1:0] base,
                                                   input logic [VB-1:0] cand);
      verdict_type     v;
      logic [2*VB-1:0] n;
      logic [2*VB-1:0] nm1;
      logic [2*VB-1:0] odd_part;
      logic [2*VB-1:0] sq;
      logic [2*VB-1:0] acc;
      logic [2*VB-1:0] e;
      int              twos;
      v = '0;
      if (cand < 3) begin
         v.bad_candidate = 1'b1;
         return v;
      end
      n        = {{VB{1'b0}}, cand};
      nm1      = n - (2 * VB)'(1);
      odd_part = nm1;
      twos     = 0;
      while (odd_part[0] == 1'b0) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      acc = (2 * VB)'(1);
      sq  = base % n;
      e   = odd_part;
      while (e != 0) begin
         if (e[0]) begin
            acc = (acc * sq) % n;
         end
         sq = (sq * sq) % n;
         e  = e >> 1;
      end
      if (acc == 1 || acc == nm1) begin
         v.probably_prime = 1'b1;
         return v;
      end
      for (int j = 0; j < twos; j++) begin
         acc = (acc * acc) % n;
         if (acc == 1) begin
            return v;
         end
         if (acc == nm1) begin
            v.probably_prime = 1'b1;
            return v;
         end
      end
      return v;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
      reports_shown = 0;
   end

   always @(posedge clock) begin : watch
      verdict_type want;
      verdict_type got;
      if (!reset) begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            verdict_q.push_back(predict_verdict(req_tdata[VB-1:0], req_tdata[2*VB-1:VB]));
            pending_count++;
         end
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got.probably_prime = rsp_tdata[0];
            got.bad_candidate  = rsp_tdata[1];
            if (verdict_q.size() == 0) begin
               error_count++;
               if (reports_shown < 10) begin
                  reports_shown++;
                  $display("%0t: response beat with nothing outstanding: pp=%b bad=%b",
                           $realtime, got.probably_prime, got.bad_candidate);
               end
            end else begin
               want = verdict_q.pop_front();
               pending_count--;
               if (got !== want) begin
                  error_count++;
                  if (reports_shown < 10) begin
                     reports_shown++;
                     $display("%0t: verdict mismatch: expected pp=%b bad=%b, got pp=%b bad=%b",
                              $realtime, want.probably_prime, want.bad_candidate,
                              got.probably_prime, got.bad_candidate);
                  end
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_miller_rabin_witness_test_core.sv =====
// Testbench top for the Miller-Rabin witness test core: clock, reset, request and
// response stimulus, and the verdict. Uses mrwt_pkg, the core and mrwt_checker.
`timescale 1ns / 100ps

module tb_miller_rabin_witness_test_core;

   localparam int VB        = mrwt_pkg::VALUE_BITS;
   localparam int N_RANDOM  = 580;
   localparam int HOLD_AT   = 150;
   localparam int HOLD_LONG = 3000;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [mrwt_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [mrwt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   int                                 error_count;
   int                                 pending_count;
   int                                 rsp_taken;
   logic                               tx_calm;
   logic                               rx_calm;

   int primes[12]      = '{3, 5, 7, 13, 97, 257, 7681, 12289, 16381, 32717, 32719, 32749};
   int pseudoprimes[15] = '{561, 1105, 1729, 2047, 2465, 2821, 3277, 4033, 4681, 6601,
                            8321, 8911, 10585, 15841, 29341};

   miller_rabin_witness_test_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mrwt_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("miller_rabin_witness_test_core test failed");
      $finish;
   end

   // Offer one request beat after a random gap and hold it until it is taken.
   task automatic send_beat(input int base, input int cand);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(mrwt_pkg::REQ_DATA_BITS - 2 * VB){1'b0}},
                     cand[VB-1:0], base[VB-1:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic send_random_beat();
      int pick;
      int cand;
      int base;
      int mult;
      pick = $urandom_range(0, 99);
      base = $urandom_range(0, 32767);
      if (pick < 60) begin
         cand = $urandom_range(3, 32767) | 1;
      end else if (pick < 72) begin
         cand = primes[$urandom_range(0, 11)];
      end else if (pick < 80) begin
         cand = pseudoprimes[$urandom_range(0, 14)];
      end else if (pick < 90) begin
         cand = $urandom_range(0, 32767);
      end else if (pick < 95) begin
         cand = $urandom_range(0, 2);
      end else begin
         cand = $urandom_range(3, 32767) | 1;
         case ($urandom_range(0, 4))
            0: begin
               mult = 32767 / cand;
               base = cand * $urandom_range(0, mult);
            end
            1: base = 0;
            2: base = 1;
            3: base = cand - 1;
            default: base = 32767;
         endcase
      end
      send_beat(base, cand);
   endtask

   // Response side: random back-pressure, with one long hold-off after HOLD_AT responses.
   initial begin : response_side
      int gap;
      rsp_tready = 1'b0;
      rsp_taken  = 0;
      rx_calm    = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_taken % 40 == 0) begin
            rx_calm = ($urandom_range(0, 3) == 0);
         end
         gap = rx_calm ? 0 : $urandom_range(0, 6);
         if (rsp_taken == HOLD_AT) begin
            gap = HOLD_LONG;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
         rsp_taken++;
      end
   end

   initial begin : request_side
      int drain;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      tx_calm    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: candidates below three, even candidates, bases that are
      // multiples of the candidate, strong pseudoprimes and field extremes.
      send_beat(5, 0);
      send_beat(32767, 1);
      send_beat(3, 2);
      send_beat(2, 3);
      send_beat(0, 3);
      send_beat(3, 4);
      send_beat(32767, 32766);
      send_beat(1, 32767);
      send_beat(32767, 32767);
      send_beat(0, 32767);
      send_beat(32767, 32749);
      send_beat(32748, 32749);
      send_beat(2, 32749);
      send_beat(1, 12289);
      send_beat(11, 12289);
      send_beat(2, 2047);
      send_beat(3, 2047);
      send_beat(2, 341);
      send_beat(2, 561);
      send_beat(21, 7);
      send_beat(32760, 5);
      send_beat(9, 10);
      send_beat(5, 9);
      send_beat(16383, 16385);
      send_beat(3, 16381);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 50 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
         end
         send_random_beat();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      // Let any stray beat show up before the verdict.
      for (drain = 0; drain < 1000; drain++) @(posedge clock);

      if (error_count == 0) begin
         $display("miller_rabin_witness_test_core test passed");
      end else begin
         $display("miller_rabin_witness_test_core test failed");
      end
      $finish;
   end

endmodule
